// File: hw/rtl/assert_macros.svh
// Assertion helpers for the hash table block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hw/rtl/lph_pkg.sv
package lph_pkg;
   localparam int SLOT_COUNT = 256;
   localparam int SLOT_BITS = 8;
   localparam int SIZE_BITS = 9;
   localparam int KEY_BYTES = 8;
   localparam int KEY_WIDTH = 64;
   localparam int LEN_BITS = 4;
   localparam int VALUE_WIDTH = 32;
   localparam logic [63:0] HASH_SEED = 64'd5381;
   localparam int HASH_SHIFT = 5;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   localparam logic [1:0] ST_EMPTY = 2'd0;
   localparam logic [1:0] ST_USED = 2'd1;
   localparam logic [1:0] ST_DEAD = 2'd2;

   localparam logic [1:0] RES_OK = 2'd0;
   localparam logic [1:0] RES_NOT_FOUND = 2'd1;
   localparam logic [1:0] RES_FULL = 2'd2;

   typedef struct packed {
      logic [KEY_WIDTH-1:0] key;
      logic [LEN_BITS-1:0] len;
      logic [VALUE_WIDTH-1:0] value;
      logic [1:0] status;
   } slot_type;

   typedef struct packed {
      logic full_en;
      logic status_en;
      logic [SLOT_BITS-1:0] addr;
   } slot_wr_type;
endpackage

// File: hw/rtl/lph_hash.sv
module lph_hash import lph_pkg::*; (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [KEY_WIDTH-1:0] key_in,
   input logic [LEN_BITS-1:0] len_in,
   input logic [SIZE_BITS-1:0] size_in,
   output logic done,
   output logic [SLOT_BITS-1:0] index
);
   localparam logic [1:0] H_IDLE = 2'd0;
   localparam logic [1:0] H_MIX = 2'd1;
   localparam logic [1:0] H_MOD = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [63:0] hash_ff, hash_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in_nx;
   logic [5:0] cnt_ff, cnt_in;
   logic [LEN_BITS-1:0] len_ff, len_nx;
   logic [SIZE_BITS-1:0] size_ff, size_nx;
   logic [SIZE_BITS-1:0] rem_ff, rem_in;
   logic done_ff, done_in;
   logic [SIZE_BITS:0] trial;

   assign trial = {rem_ff, hash_ff[63]};

   always_comb begin
      phase_in = phase_ff;
      hash_in = hash_ff;
      key_in_nx = key_ff;
      cnt_in = cnt_ff;
      len_nx = len_ff;
      size_nx = size_ff;
      rem_in = rem_ff;
      done_in = 1'b0;
      case (phase_ff)
         H_IDLE: begin
            if (start) begin
               phase_in = H_MIX;
               hash_in = HASH_SEED;
               key_in_nx = key_in;
               len_nx = len_in;
               size_nx = size_in;
               cnt_in = '0;
            end
         end
         H_MIX: begin
            if (cnt_ff[LEN_BITS-1:0] == len_ff) begin
               phase_in = H_MOD;
               cnt_in = '0;
               rem_in = '0;
            end else begin
               hash_in = (hash_ff << HASH_SHIFT) + hash_ff + {56'd0, key_ff[7:0]};
               key_in_nx = key_ff >> 8;
               cnt_in = cnt_ff + 6'd1;
            end
         end
         H_MOD: begin
            hash_in = hash_ff << 1;
            if (trial >= {1'b0, size_ff}) begin
               rem_in = SIZE_BITS'(trial - {1'b0, size_ff});
            end else begin
               rem_in = trial[SIZE_BITS-1:0];
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               phase_in = H_IDLE;
               done_in = 1'b1;
            end
         end
         default: begin
            phase_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= H_IDLE;
         done_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff <= done_in;
      end
      hash_ff <= hash_in;
      key_ff <= key_in_nx;
      cnt_ff <= cnt_in;
      len_ff <= len_nx;
      size_ff <= size_nx;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign index = rem_ff[SLOT_BITS-1:0];
endmodule

// File: hw/rtl/lph_store.sv
module lph_store import lph_pkg::*; (
   input logic clock,
   input logic reset,
   input logic rd_en,
   input logic [SLOT_BITS-1:0] rd_addr,
   output slot_type rd_data,
   input slot_wr_type wr,
   input slot_type wr_data
);
   logic [KEY_WIDTH-1:0] key_mem [SLOT_COUNT];
   logic [LEN_BITS-1:0] len_mem [SLOT_COUNT];
   logic [VALUE_WIDTH-1:0] value_mem [SLOT_COUNT];
   logic [1:0] status_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] valid_ff;
   slot_type rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.full_en || wr.status_en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.full_en) begin
         key_mem[wr.addr] <= wr_data.key;
         len_mem[wr.addr] <= wr_data.len;
         value_mem[wr.addr] <= wr_data.value;
      end
      if (wr.full_en || wr.status_en) begin
         status_mem[wr.addr] <= wr_data.status;
      end
      if (rd_en) begin
         rd_ff.key <= key_mem[rd_addr];
         rd_ff.len <= len_mem[rd_addr];
         rd_ff.value <= value_mem[rd_addr];
         rd_ff.status <= valid_ff[rd_addr] ? status_mem[rd_addr] : ST_EMPTY;
      end
   end

   assign rd_data = rd_ff;
endmodule

// File: hw/rtl/linear_probe_hash_table.sv
// Linear-probing hash table with djb2 hashing over a 256-slot store.
// req channel: one request item (insert, search or delete) on a key of up to
// eight bytes and a 32-bit value. rsp channel: exactly one result item per
// request, giving status, value read and slot index.
// csr port: csr_we writes the active table size (1..256, 0 reads as 1,
// larger values as 256); write it only while no request is in flight.
// From accept to rsp_tvalid: djb2 mixing over the key bytes (one byte a cycle),
// bit-serial modulo by the table size, handing over the index, then per slot
// probed a memory read and a compare, and at last the result load.
// One request is worked on at a time; req_tready is high while idle, from the
// cycle after the result load.
// A result that waits in the output register does not block the next request;
// only the next result load waits for rsp_tready while that register is full.
// Reset: synchronous, marks all slots empty through per-slot valid bits,
// sets table size to 256 and drops any pending result.
`include "assert_macros.svh"

module linear_probe_hash_table import lph_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   // operation[1:0], key_bytes[65:2], key_length[69:66], value[101:70], zero pad
   input logic [103:0] req_tdata,
   output logic rsp_tvalid,
   input logic rsp_tready,
   // status[1:0], value_out[33:2], slot_index[41:34], zero pad
   output logic [47:0] rsp_tdata,
   input logic csr_we,
   input logic [SIZE_BITS-1:0] csr_wdata
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_HASH = 3'd1;
   localparam logic [2:0] S_RD = 3'd2;
   localparam logic [2:0] S_CHK = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [SIZE_BITS-1:0] size_ff;
   logic [SIZE_BITS-1:0] act_size_ff, act_size_in;
   logic [1:0] op_ff, op_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [LEN_BITS-1:0] len_ff, len_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [SLOT_BITS-1:0] idx_ff, idx_in;
   logic [SIZE_BITS-1:0] n_ff, n_in;
   logic [1:0] res_st_ff, res_st_in;
   logic [VALUE_WIDTH-1:0] res_val_ff, res_val_in;
   logic [SLOT_BITS-1:0] res_slot_ff, res_slot_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] out_st_ff;
   logic [VALUE_WIDTH-1:0] out_val_ff;
   logic [SLOT_BITS-1:0] out_slot_ff;
   logic accept, hash_done, rd_en, last_probe, is_match, load_rsp;
   logic [SLOT_BITS-1:0] hash_idx, idx_next;
   logic [LEN_BITS-1:0] req_len;
   logic [KEY_WIDTH-1:0] req_key;
   slot_type rd_data, wr_data;
   slot_wr_type wr;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign load_rsp = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      req_len = req_tdata[69:66];
      if (req_len > LEN_BITS'(KEY_BYTES)) begin
         req_len = LEN_BITS'(KEY_BYTES);
      end
      for (int i = 0; i < KEY_BYTES; i++) begin
         req_key[8*i +: 8] = (LEN_BITS'(i) < req_len) ? req_tdata[2 + 8*i +: 8] : 8'd0;
      end
      if (size_ff == '0) begin
         act_size_in = SIZE_BITS'(1);
      end else if (size_ff > SIZE_BITS'(SLOT_COUNT)) begin
         act_size_in = SIZE_BITS'(SLOT_COUNT);
      end else begin
         act_size_in = size_ff;
      end
   end

   lph_hash u_hash (
      .clock(clock), .reset(reset), .start(accept),
      .key_in(req_key), .len_in(req_len), .size_in(act_size_in),
      .done(hash_done), .index(hash_idx)
   );

   assign rd_en = (state_ff == S_RD);

   lph_store u_store (
      .clock(clock), .reset(reset), .rd_en(rd_en), .rd_addr(idx_ff),
      .rd_data(rd_data), .wr(wr), .wr_data(wr_data)
   );

   assign last_probe = (n_ff == act_size_ff - SIZE_BITS'(1));
   assign idx_next = ({1'b0, idx_ff} + SIZE_BITS'(1) == act_size_ff) ? '0
                                                                      : idx_ff + 8'd1;
   assign is_match = (rd_data.status == ST_USED) && (rd_data.len == len_ff)
                     && (rd_data.key == key_ff);

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      key_in = key_ff;
      len_in = len_ff;
      val_in = val_ff;
      idx_in = idx_ff;
      n_in = n_ff;
      res_st_in = res_st_ff;
      res_val_in = res_val_ff;
      res_slot_in = res_slot_ff;
      wr = '0;
      wr.addr = idx_ff;
      wr_data.key = key_ff;
      wr_data.len = len_ff;
      wr_data.value = val_ff;
      wr_data.status = ST_USED;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_tdata[1:0];
               key_in = req_key;
               len_in = req_len;
               val_in = req_tdata[101:70];
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               idx_in = hash_idx;
               n_in = '0;
               res_st_in = (op_ff == OP_INSERT) ? RES_FULL : RES_NOT_FOUND;
               res_val_in = '0;
               res_slot_in = '0;
               if (op_ff == OP_INSERT || op_ff == OP_SEARCH || op_ff == OP_DELETE) begin
                  state_in = S_RD;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            state_in = S_RD;
            if (op_ff == OP_INSERT && rd_data.status != ST_USED) begin
               wr.full_en = 1'b1;
               res_st_in = RES_OK;
               res_slot_in = idx_ff;
               state_in = S_RESP;
            end else if (op_ff != OP_INSERT && rd_data.status == ST_EMPTY) begin
               state_in = S_RESP;
            end else if (op_ff != OP_INSERT && is_match) begin
               res_st_in = RES_OK;
               res_slot_in = idx_ff;
               if (op_ff == OP_SEARCH) begin
                  res_val_in = rd_data.value;
               end else begin
                  wr.status_en = 1'b1;
                  wr_data.status = ST_DEAD;
               end
               state_in = S_RESP;
            end else if (last_probe) begin
               state_in = S_RESP;
            end else begin
               idx_in = idx_next;
               n_in = n_ff + SIZE_BITS'(1);
            end
         end
         S_RESP: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         size_ff <= SIZE_BITS'(SLOT_COUNT);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            size_ff <= csr_wdata;
         end
      end
      if (accept) begin
         act_size_ff <= act_size_in;
      end
      op_ff <= op_in;
      key_ff <= key_in;
      len_ff <= len_in;
      val_ff <= val_in;
      idx_ff <= idx_in;
      n_ff <= n_in;
      res_st_ff <= res_st_in;
      res_val_ff <= res_val_in;
      res_slot_ff <= res_slot_in;
      if (load_rsp) begin
         out_st_ff <= res_st_ff;
         out_val_ff <= res_val_ff;
         out_slot_ff <= res_slot_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {6'd0, out_slot_ff, out_val_ff, out_st_ff};

   `ASSERT_SAME(a_probe_in_range, state_ff == S_CHK, {1'b0, idx_ff} < act_size_ff)
   `ASSERT_SAME(a_count_in_range, state_ff == S_CHK, n_ff < act_size_ff)
   `ASSERT_NEXT(a_read_then_check, state_ff == S_RD, state_ff == S_CHK)
   `ASSERT_SAME(a_no_write_outside_check, wr.full_en || wr.status_en, state_ff == S_CHK)
endmodule

// File: sim/tb.sv
module tb;
   import lph_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [103:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [SIZE_BITS-1:0] csr_wdata = '0;

   int errors = 0;
   int idle_cycles = 0;
   int sink_wait = 0;
   bit sink_random = 1'b1;

   always #10 clock = ~clock;

   linear_probe_hash_table dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   typedef struct packed {
      logic [1:0] status;
      logic [31:0] value_out;
      logic [7:0] slot_index;
   } outcome_type;

   task automatic report(input string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   class hash_table_scoreboard;
      logic [63:0] keys [SLOT_COUNT];
      logic [3:0] lens [SLOT_COUNT];
      logic [31:0] vals [SLOT_COUNT];
      logic [1:0] states [SLOT_COUNT];
      logic [SIZE_BITS-1:0] size_reg;
      outcome_type pending[$];

      function void clear();
         foreach (states[i]) states[i] = ST_EMPTY;
         size_reg = 9'd256;
         pending.delete();
      endfunction

      function void note_request(input logic [1:0] op, input logic [63:0] kb,
                                 input logic [3:0] klen, input logic [31:0] v);
         int unsigned sz, len, idx;
         logic [63:0] key, h;
         outcome_type o;
         sz = (size_reg == 0) ? 1 : (size_reg > SLOT_COUNT ? SLOT_COUNT : size_reg);
         len = (klen > KEY_BYTES) ? KEY_BYTES : klen;
         key = '0;
         h = HASH_SEED;
         for (int i = 0; i < len; i++) begin
            key[8*i +: 8] = kb[8*i +: 8];
            h = (h << HASH_SHIFT) + h + {56'd0, kb[8*i +: 8]};
         end
         idx = 32'(h % 64'(sz));
         o = '{status: RES_NOT_FOUND, value_out: '0, slot_index: '0};
         if (op == OP_INSERT) begin
            o.status = RES_FULL;
            for (int n = 0; n < sz; n++) begin
               if (states[idx] != ST_USED) begin
                  states[idx] = ST_USED;
                  keys[idx] = key;
                  lens[idx] = 4'(len);
                  vals[idx] = v;
                  o.status = RES_OK;
                  o.slot_index = 8'(idx);
                  break;
               end
               idx = (idx + 1 == sz) ? 0 : idx + 1;
            end
         end else if (op == OP_SEARCH || op == OP_DELETE) begin
            for (int n = 0; n < sz; n++) begin
               if (states[idx] == ST_EMPTY) break;
               if (states[idx] == ST_USED && lens[idx] == len && keys[idx] == key) begin
                  o.status = RES_OK;
                  o.slot_index = 8'(idx);
                  if (op == OP_SEARCH) o.value_out = vals[idx];
                  else states[idx] = ST_DEAD;
                  break;
               end
               idx = (idx + 1 == sz) ? 0 : idx + 1;
            end
         end
         pending.push_back(o);
      endfunction

      task check_result(input logic [47:0] d);
         outcome_type e;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result %h", d));
            return;
         end
         e = pending.pop_front();
         if (d[1:0] !== e.status)
            report($sformatf("status %0d, want %0d", d[1:0], e.status));
         if (d[33:2] !== e.value_out)
            report($sformatf("value_out %h, want %h", d[33:2], e.value_out));
         if (d[41:34] !== e.slot_index)
            report($sformatf("slot_index %0d, want %0d", d[41:34], e.slot_index));
         if (d[47:42] !== 6'd0) report("nonzero pad");
      endtask
   endclass

   hash_table_scoreboard board = new();

   logic [63:0] key_pool [16];
   logic [3:0] len_pool [16];

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb failed");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      int w;
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_wait <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         w = sink_random ? $urandom_range(0, 3) : 0;
         sink_wait <= w;
         rsp_tready <= (w == 0);
      end else if (!rsp_tready) begin
         if (sink_wait == 0) rsp_tready <= 1'b1;
         else if (rsp_tvalid) sink_wait <= sink_wait - 1;
      end
   end

   task automatic send(input logic [1:0] op, input logic [63:0] kb,
                       input logic [3:0] klen, input logic [31:0] v);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= {2'b00, v, klen, kb, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_request(op, kb, klen, v);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_size(input logic [SIZE_BITS-1:0] s);
      drain();
      csr_wdata <= s;
      csr_we <= 1'b1;
      @(posedge clock);
      board.size_reg = s;
      csr_we <= 1'b0;
   endtask

   task automatic random_item(input int mode);
      int k;
      logic [63:0] kb;
      logic [63:0] upper;
      logic [3:0] klen;
      logic [1:0] op;
      k = $urandom_range(0, 15);
      if (mode == 0 || $urandom_range(0, 9) == 0) begin
         kb = {$urandom, $urandom};
         klen = 4'($urandom_range(0, 15));
      end else begin
         kb = key_pool[k];
         upper = ~((64'd1 << (8 * len_pool[k])) - 1);
         if ($urandom_range(0, 3) == 0) kb = kb ^ ({$urandom, $urandom} & upper);
         klen = len_pool[k];
      end
      op = 2'($urandom_range(0, 3));
      if (op == 2'd3 && $urandom_range(0, 3) != 0) op = OP_SEARCH;
      send(op, kb, klen, $urandom);
   endtask

   initial begin
      int sizes [6] = '{256, 1, 0, 7, 300, 511};
      board.clear();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 16; i++) begin
         key_pool[i] = {$urandom, $urandom};
         len_pool[i] = 4'($urandom_range(0, 8));
         if (len_pool[i] < 8) key_pool[i] &= (64'd1 << (8 * len_pool[i])) - 1;
      end
      send(OP_SEARCH, 64'd0, 4'd0, 32'd0);
      send(OP_INSERT, 64'd0, 4'd0, 32'hFFFF_FFFF);
      send(OP_INSERT, 64'd0, 4'd1, 32'h1234_5678);
      send(OP_SEARCH, 64'd0, 4'd0, 32'd0);
      send(OP_SEARCH, 64'd0, 4'd1, 32'd0);
      send(OP_INSERT, '1, 4'd15, 32'h0);
      send(OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'd0);
      send(OP_INSERT, 64'h00FF, 4'd2, 32'hA5A5_A5A5);
      send(OP_SEARCH, 64'hAB00_FF, 4'd2, 32'd0);
      send(OP_DELETE, 64'd0, 4'd1, 32'd0);
      send(OP_SEARCH, 64'd0, 4'd1, 32'd0);
      send(OP_DELETE, 64'd0, 4'd1, 32'd0);
      send(2'd3, '1, 4'd8, '1);
      write_size(9'd1);
      send(OP_INSERT, 64'h41, 4'd1, 32'd7);
      send(OP_INSERT, 64'h42, 4'd1, 32'd8);
      send(OP_SEARCH, 64'h42, 4'd1, 32'd0);
      send(OP_DELETE, 64'h41, 4'd1, 32'd0);
      send(OP_INSERT, 64'h42, 4'd1, 32'd9);
      send(OP_SEARCH, 64'h42, 4'd1, 32'd0);
      for (int p = 0; p < 6; p++) begin
         write_size(9'(sizes[p]));
         for (int i = 0; i < 200; i++) random_item(i < 20 ? 0 : 1);
      end
      sink_random = 1'b0;
      write_size(9'd4);
      for (int i = 0; i < 30; i++) random_item(1);
      drain();
      if (errors == 0 && board.pending.size() == 0) begin
         $display("tb passed");
      end else begin
         foreach (board.pending[i]) report("result never arrived");
         $display("tb failed");
      end
      $finish;
   end
endmodule
